@@ hdl/srdf_pkg.sv @@
`timescale 1ns / 1ps

package srdf_pkg;

	// Default queue depth; a queue holds at most depth-1 bytes
	localparam int unsigned QUEUE_DEPTH_DEF = 256;

	// Entries in the command queue between front and back end
	localparam int unsigned CMDQ_DEPTH = 2;

	// Scancodes
	localparam logic [7:0] SC_NULL      = 8'h00;
	localparam logic [7:0] SC_PREFIX    = 8'hE0;
	localparam logic [7:0] SC_KEY_C     = 8'h2E;
	localparam logic [7:0] SC_PGUP      = 8'h49;
	localparam logic [7:0] SC_PGUP_REL  = 8'hC9;
	localparam logic [7:0] SC_PGDN      = 8'h51;
	localparam logic [7:0] SC_PGDN_REL  = 8'hD1;
	localparam logic [7:0] SC_TAB       = 8'h0F;
	localparam logic [7:0] SC_TAB_REL   = 8'h8F;

	// Input operation codes
	typedef enum logic [2:0] {
		OP_CTRL_BYTE = 3'd0,
		OP_ENQUEUE   = 3'd1,
		OP_READ      = 3'd2,
		OP_FLUSH_ALL = 3'd3,
		OP_FLUSH_APP = 3'd4
	} op_t;

	// Result event codes
	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_MOUSE = 3'd1,
		EV_INTR  = 3'd2,
		EV_PREV  = 3'd3,
		EV_NEXT  = 3'd4,
		EV_READ  = 3'd5
	} ev_t;

	// Work handed from the front end to the back end
	typedef enum logic [2:0] {
		CMD_RESULT    = 3'd0,
		CMD_PUSH      = 3'd1,
		CMD_READ      = 3'd2,
		CMD_FLUSH_ALL = 3'd3,
		CMD_FLUSH_APP = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		ev_t         ev;        // event for CMD_RESULT
		logic [7:0]  data;      // byte to push, or result byte
		logic        sel_app;   // target app queue
		logic        prefix;    // push 0xE0 ahead of data
		logic        fallback;  // read falls back to shell queue
	} cmd_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		B_IDLE  = 2'd0,
		B_PUSH2 = 2'd1,
		B_READ  = 2'd2
	} back_state_t;

endpackage

@@ hdl/srdf_front.sv @@
`timescale 1ns / 1ps

module srdf_front import srdf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       aux_flag,
	input  logic       ctrl_held,
	input  logic       alt_held,
	input  logic       wm_active,
	input  logic       batch_running,
	input  logic       separate_windows,
	input  logic       fg_text_only,
	input  logic       is_foreground,
	input  logic       cmdq_full,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic app_mode_q;
	logic prefix_q;
	logic prefix_d;
	logic focused;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_mode_q <= 1'b0;
		end else if (cfg_wr_en) begin
			app_mode_q <= cfg_wr_data;
		end
	end

	assign in_stall = cmdq_full;
	assign cmd_push = in_valid && !cmdq_full;
	assign focused  = wm_active && !(batch_running && separate_windows && fg_text_only);

	// Classify the transaction into one command
	always_comb begin
		prefix_d     = prefix_q;
		cmd.kind     = CMD_RESULT;
		cmd.ev       = EV_NONE;
		cmd.data     = SC_NULL;
		cmd.sel_app  = 1'b0;
		cmd.prefix   = 1'b0;
		cmd.fallback = 1'b0;
		case (operation)
			OP_CTRL_BYTE: begin
				if (aux_flag) begin
					cmd.ev   = EV_MOUSE;
					cmd.data = data_byte;
				end else if (data_byte == SC_NULL) begin
					// null scancode, nothing to do
				end else if (data_byte == SC_PREFIX) begin
					prefix_d = 1'b1;
				end else if (data_byte == SC_KEY_C && ctrl_held && !focused) begin
					cmd.ev = EV_INTR;
				end else if (data_byte inside {SC_PGUP, SC_PGUP_REL} && ctrl_held
						&& batch_running) begin
					prefix_d = 1'b0;
					cmd.ev   = (data_byte == SC_PGUP) ? EV_PREV : EV_NONE;
				end else if (data_byte inside {SC_PGDN, SC_PGDN_REL} && ctrl_held
						&& batch_running) begin
					prefix_d = 1'b0;
					cmd.ev   = (data_byte == SC_PGDN) ? EV_NEXT : EV_NONE;
				end else if (data_byte inside {SC_TAB, SC_TAB_REL} && alt_held
						&& batch_running && !wm_active) begin
					prefix_d = 1'b0;
					cmd.ev   = (data_byte == SC_TAB) ? EV_NEXT : EV_NONE;
				end else begin
					// plain scancode: queue it, prefix first if pending
					prefix_d    = 1'b0;
					cmd.kind    = CMD_PUSH;
					cmd.data    = data_byte;
					cmd.sel_app = app_mode_q || wm_active;
					cmd.prefix  = prefix_q;
				end
			end
			OP_ENQUEUE: begin
				if (data_byte != SC_NULL) begin
					cmd.kind    = CMD_PUSH;
					cmd.data    = data_byte;
					cmd.sel_app = app_mode_q;
				end
			end
			OP_READ: begin
				cmd.ev = EV_READ;
				if (wm_active || is_foreground) begin
					cmd.kind     = CMD_READ;
					cmd.sel_app  = app_mode_q || wm_active;
					cmd.fallback = wm_active;
				end
			end
			OP_FLUSH_ALL: cmd.kind = CMD_FLUSH_ALL;
			OP_FLUSH_APP: cmd.kind = CMD_FLUSH_APP;
			default: ;
		endcase
	end

	// Pending prefix flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= 1'b0;
		end else if (cmd_push) begin
			prefix_q <= prefix_d;
		end
	end

endmodule

@@ hdl/srdf_cmdq.sv @@
`timescale 1ns / 1ps

module srdf_cmdq import srdf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t pop_cmd
);

	localparam int unsigned PW = $clog2(CMDQ_DEPTH);
	localparam int unsigned CW = $clog2(CMDQ_DEPTH + 1);

	cmd_t          slot_q [CMDQ_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(CMDQ_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = slot_q[rd_ptr_q];

	// Slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/srdf_back.sv @@
`timescale 1ns / 1ps

module srdf_back import srdf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] out_byte
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
		ptr_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	back_state_t   state_q, state_d;
	logic [7:0]    shell_mem [QUEUE_DEPTH];
	logic [7:0]    app_mem [QUEUE_DEPTH];
	logic [AW-1:0] shell_head_q, shell_tail_q, app_head_q, app_tail_q;
	logic [7:0]    shell_rd_q, app_rd_q;
	logic          rd_app_q;
	logic [7:0]    pend_byte_q;
	logic          pend_app_q;
	logic          out_valid_q;
	ev_t           out_ev_q;
	logic [7:0]    out_byte_q;

	logic          out_free, take;
	logic          app_empty, shell_empty, pop_app, pop_shell;
	logic          load;
	ev_t           ld_ev;
	logic [7:0]    ld_byte;
	logic          wr_en, wr_app;
	logic [7:0]    wr_byte;
	logic          rd_en, rd_app;
	logic          flush_app, flush_shell;
	logic [AW-1:0] sel_head, sel_tail, head_nx;
	logic          drop;

	assign out_free    = !out_valid_q || !out_stall;
	assign take        = (state_q == B_IDLE) && cmd_valid && out_free;
	assign app_empty   = (app_head_q == app_tail_q);
	assign shell_empty = (shell_head_q == shell_tail_q);
	assign pop_app     = cmd.sel_app && !app_empty;
	assign pop_shell   = !shell_empty && (!cmd.sel_app || (app_empty && cmd.fallback));

	// Sequencer: next state, memory port control, result load
	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		load        = 1'b0;
		ld_ev       = EV_NONE;
		ld_byte     = SC_NULL;
		wr_en       = 1'b0;
		wr_app      = 1'b0;
		wr_byte     = SC_NULL;
		rd_en       = 1'b0;
		rd_app      = 1'b0;
		flush_app   = 1'b0;
		flush_shell = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (take) begin
					cmd_pop = 1'b1;
					case (cmd.kind)
						CMD_PUSH: begin
							wr_en   = 1'b1;
							wr_app  = cmd.sel_app;
							wr_byte = cmd.prefix ? SC_PREFIX : cmd.data;
							load    = 1'b1;
							if (cmd.prefix) begin
								state_d = B_PUSH2;
							end
						end
						CMD_READ: begin
							if (pop_app || pop_shell) begin
								rd_en   = 1'b1;
								rd_app  = pop_app;
								state_d = B_READ;
							end else begin
								load  = 1'b1;
								ld_ev = EV_READ;
							end
						end
						CMD_FLUSH_ALL: begin
							flush_app   = 1'b1;
							flush_shell = 1'b1;
							load        = 1'b1;
						end
						CMD_FLUSH_APP: begin
							flush_app = 1'b1;
							load      = 1'b1;
						end
						CMD_RESULT: begin
							load    = 1'b1;
							ld_ev   = cmd.ev;
							ld_byte = cmd.data;
						end
						default: load = 1'b1;
					endcase
				end
			end
			B_PUSH2: begin
				// second write of a prefixed scancode
				wr_en   = 1'b1;
				wr_app  = pend_app_q;
				wr_byte = pend_byte_q;
				state_d = B_IDLE;
			end
			B_READ: begin
				// output register is empty here: nothing was loaded on issue
				load    = 1'b1;
				ld_ev   = EV_READ;
				ld_byte = rd_app_q ? app_rd_q : shell_rd_q;
				state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	// Push pointer math for the queue being written
	assign sel_head = wr_app ? app_head_q : shell_head_q;
	assign sel_tail = wr_app ? app_tail_q : shell_tail_q;
	assign head_nx  = ptr_next(sel_head);
	assign drop     = (head_nx == sel_tail);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			out_valid_q  <= 1'b0;
			shell_head_q <= '0;
			shell_tail_q <= '0;
			app_head_q   <= '0;
			app_tail_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			// shell queue pointers
			if (flush_shell) begin
				shell_head_q <= '0;
				shell_tail_q <= '0;
			end else if (wr_en && !wr_app) begin
				shell_head_q <= head_nx;
				if (drop) begin
					shell_tail_q <= ptr_next(shell_tail_q);
				end
			end else if (rd_en && !rd_app) begin
				shell_tail_q <= ptr_next(shell_tail_q);
			end
			// app queue pointers
			if (flush_app) begin
				app_head_q <= '0;
				app_tail_q <= '0;
			end else if (wr_en && wr_app) begin
				app_head_q <= head_nx;
				if (drop) begin
					app_tail_q <= ptr_next(app_tail_q);
				end
			end else if (rd_en && rd_app) begin
				app_tail_q <= ptr_next(app_tail_q);
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (load) begin
			out_ev_q   <= ld_ev;
			out_byte_q <= ld_byte;
		end
		if (cmd_pop) begin
			pend_byte_q <= cmd.data;
			pend_app_q  <= cmd.sel_app;
		end
		if (rd_en) begin
			rd_app_q <= rd_app;
		end
	end

	// Queue memories, one write and one registered read each
	always_ff @(posedge clk) begin
		if (wr_en && !wr_app) begin
			shell_mem[shell_head_q] <= wr_byte;
		end
		if (rd_en && !rd_app) begin
			shell_rd_q <= shell_mem[shell_tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && wr_app) begin
			app_mem[app_head_q] <= wr_byte;
		end
		if (rd_en && rd_app) begin
			app_rd_q <= app_mem[app_tail_q];
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_ev_q;
	assign out_byte  = out_byte_q;

`ifndef ASSERT_OFF
	a_read_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_READ) |=> out_valid_q)
		else $error("issued read did not produce a result");

	a_shell_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !wr_app) |=> (shell_head_q != shell_tail_q))
		else $error("shell queue empty right after a push");

	a_app_push_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && wr_app) |=> (app_head_q != app_tail_q))
		else $error("app queue empty right after a push");

	a_push2_from_take: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_PUSH2) |-> $past(cmd_pop))
		else $error("second push write without a taken command");
`endif

endmodule

@@ hdl/scancode_router_dual_fifo.sv @@
`timescale 1ns / 1ps

// Keyboard byte router with a shell queue and an app queue, both dropping the
// oldest byte when full. A front end classifies each transaction in the cycle
// it is accepted (hotkeys, mouse bytes, prefix tracking, queue selection) and
// drops a command into a two-entry queue; a back end executes it against the
// two byte memories and registers the one result. A prefixed scancode passes
// through B_PUSH2 for its second write (the queue memory has a single write
// port), and a read that pops passes through B_READ for the registered memory
// read; the back end takes no new command until it is back in B_IDLE.
// Queue memories are not cleared after reset; head and tail indices are.
module scancode_router_dual_fifo import srdf_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic       cfg_wr_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] operation,
	input  logic [7:0] data_byte,
	input  logic       aux_flag,
	input  logic       ctrl_held,
	input  logic       alt_held,
	input  logic       wm_active,
	input  logic       batch_running,
	input  logic       separate_windows,
	input  logic       fg_text_only,
	input  logic       is_foreground,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] event_res,
	output logic [7:0] out_byte
);

	logic cmdq_full, cmdq_empty, cmd_push, cmd_pop;
	cmd_t cmd_in, cmd_out;

	srdf_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_wr_data      (cfg_wr_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.data_byte        (data_byte),
		.aux_flag         (aux_flag),
		.ctrl_held        (ctrl_held),
		.alt_held         (alt_held),
		.wm_active        (wm_active),
		.batch_running    (batch_running),
		.separate_windows (separate_windows),
		.fg_text_only     (fg_text_only),
		.is_foreground    (is_foreground),
		.cmdq_full        (cmdq_full),
		.cmd_push         (cmd_push),
		.cmd              (cmd_in)
	);

	srdf_cmdq u_cmdq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.full     (cmdq_full),
		.pop      (cmd_pop),
		.empty    (cmdq_empty),
		.pop_cmd  (cmd_out)
	);

	srdf_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmdq_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.out_byte  (out_byte)
	);

endmodule
